/* rtl/stbs_pkg.sv */
// Shared types and constants for the sorted-table binary search core.
// Used by the controller, the datapath and the top level; no dependencies.
package stbs_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int RANGE_W     = IDX_W + 1;
    localparam int BOUND_W     = IDX_W + 2;

    localparam logic OPC_LOAD   = 1'b0;
    localparam logic OPC_SEARCH = 1'b1;

    typedef logic [IDX_W-1:0]          t_idx;
    typedef logic signed [BOUND_W-1:0] t_bound;
    typedef logic signed [BOUND_W:0]   t_sum;
    typedef logic signed [KEY_W-1:0]   t_key;

    typedef enum logic [1:0] {
        DP_NOP,
        DP_START,
        DP_PROBE,
        DP_WALK
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   ram_wr;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_empty;
        logic eq;
        logic srch_empty;
        logic mid_zero;
        logic walk_zero;
    } t_dp_status;

endpackage

/* rtl/stbs_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/stbs_ctrl.sv */
// Controller state machine: input/output handshakes and sequencing of probes.
// Depends on stbs_pkg; drives the datapath through t_dp_cmd.
module stbs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  stbs_pkg::t_dp_status i_status,
    output stbs_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid & ~i_out_ready;
        o_cmd.op       = stbs_pkg::DP_NOP;
        o_cmd.ram_wr   = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == stbs_pkg::OPC_SEARCH) begin
                        o_cmd.op = stbs_pkg::DP_START;
                        n_state  = i_status.in_empty ? S_FINISH : S_PROBE;
                    end else begin
                        o_cmd.ram_wr = 1'b1;
                    end
                end
            end
            S_PROBE: begin
                o_cmd.op = stbs_pkg::DP_PROBE;
                if (i_status.eq) begin
                    n_state = i_status.mid_zero ? S_FINISH : S_WALK;
                end else if (i_status.srch_empty) begin
                    n_state = S_FINISH;
                end
            end
            S_WALK: begin
                o_cmd.op = stbs_pkg::DP_WALK;
                if (!i_status.eq || i_status.walk_zero) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/stbs_dp.sv */
// Datapath: table RAM, search bounds, midpoint, key compare and result register.
// Depends on stbs_pkg and stbs_ram; controlled by t_dp_cmd from stbs_ctrl.
module stbs_dp (
    input  logic                          i_clk,
    input  stbs_pkg::t_dp_cmd             i_cmd,
    input  logic [stbs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_entry_value,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_search_key,
    input  logic [stbs_pkg::RANGE_W-1:0]  i_range_low,
    input  logic [stbs_pkg::IDX_W-1:0]    i_range_high,
    output stbs_pkg::t_dp_status          o_status,
    output logic                          o_found,
    output logic [stbs_pkg::IDX_W-1:0]    o_position
);

    stbs_pkg::t_key   r_key;
    stbs_pkg::t_bound r_lo;
    stbs_pkg::t_bound r_hi;
    stbs_pkg::t_idx   r_mid;
    logic             r_hit;
    logic             r_out_found;
    stbs_pkg::t_idx   r_out_pos;

    logic [stbs_pkg::KEY_W-1:0] rd_data;
    stbs_pkg::t_key   rd_key;
    stbs_pkg::t_idx   rd_addr;
    stbs_pkg::t_bound in_lo;
    stbs_pkg::t_bound in_hi;
    stbs_pkg::t_sum   in_sum;
    stbs_pkg::t_idx   in_mid;
    stbs_pkg::t_bound mid_ext;
    stbs_pkg::t_bound srch_lo;
    stbs_pkg::t_bound srch_hi;
    stbs_pkg::t_sum   srch_sum;
    stbs_pkg::t_idx   srch_mid;
    stbs_pkg::t_idx   walk_mid;
    logic             key_lt;

    stbs_ram #(
        .WIDTH (stbs_pkg::KEY_W),
        .DEPTH (stbs_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.ram_wr),
        .i_wr_addr (i_entry_index),
        .i_wr_data (i_entry_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        rd_key   = stbs_pkg::t_key'(rd_data);
        in_lo    = stbs_pkg::t_bound'({1'b0, i_range_low});
        in_hi    = stbs_pkg::t_bound'({2'b00, i_range_high});
        in_sum   = stbs_pkg::t_sum'(in_lo) + stbs_pkg::t_sum'(in_hi);
        in_mid   = in_sum[stbs_pkg::IDX_W:1];
        mid_ext  = stbs_pkg::t_bound'({2'b00, r_mid});
        key_lt   = r_key < rd_key;
        srch_lo  = key_lt ? r_lo : mid_ext + stbs_pkg::t_bound'(1);
        srch_hi  = key_lt ? mid_ext - stbs_pkg::t_bound'(1) : r_hi;
        srch_sum = stbs_pkg::t_sum'(srch_lo) + stbs_pkg::t_sum'(srch_hi);
        srch_mid = srch_sum[stbs_pkg::IDX_W:1];
        walk_mid = r_mid - stbs_pkg::t_idx'(1);

        o_status.in_empty   = in_lo > in_hi;
        o_status.eq         = rd_key == r_key;
        o_status.srch_empty = srch_lo > srch_hi;
        o_status.mid_zero   = r_mid == '0;
        o_status.walk_zero  = walk_mid == '0;

        case (i_cmd.op)
            stbs_pkg::DP_START: rd_addr = in_mid;
            stbs_pkg::DP_PROBE: rd_addr = (rd_key == r_key) ? walk_mid : srch_mid;
            stbs_pkg::DP_WALK:  rd_addr = walk_mid - stbs_pkg::t_idx'(1);
            default:            rd_addr = r_mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            stbs_pkg::DP_START: begin
                r_key <= i_search_key;
                r_lo  <= in_lo;
                r_hi  <= in_hi;
                r_mid <= in_mid;
                r_hit <= 1'b0;
            end
            stbs_pkg::DP_PROBE: begin
                if (o_status.eq) begin
                    r_hit <= 1'b1;
                end else begin
                    r_lo  <= srch_lo;
                    r_hi  <= srch_hi;
                    r_mid <= srch_mid;
                end
            end
            stbs_pkg::DP_WALK: begin
                if (o_status.eq) begin
                    r_mid <= walk_mid;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_found <= r_hit;
            r_out_pos   <= r_hit ? r_mid : '0;
        end
    end

    assign o_found    = r_out_found;
    assign o_position = r_out_pos;

endmodule

/* rtl/sorted_table_binary_search_core.sv */
// Sorted-table binary search core: a load item (opcode 0) writes one signed entry
// into a 256-entry table and gives no result. A search item (opcode 1) starts,
// then runs bisection probes (at most 9 for 256 entries), then steps down below
// the hit over equal entries, checking each equal one plus the first that differs
// (none below index 0), then posts the result, held while an earlier result still
// waits to be taken; each probe and step is one read of the single read port of the
// table RAM, one read per cycle. No new item is taken until a search is through.
// Found=0 and position=0 are returned on a miss or an empty range.
// The table is not cleared at reset; searches must only touch written entries.
// Depends on stbs_pkg, stbs_ctrl, stbs_dp and stbs_ram.
module sorted_table_binary_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [stbs_pkg::IDX_W-1:0]        i_entry_index,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_entry_value,
    input  logic signed [stbs_pkg::KEY_W-1:0] i_search_key,
    input  logic [stbs_pkg::RANGE_W-1:0]      i_range_low,
    input  logic [stbs_pkg::IDX_W-1:0]        i_range_high,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [stbs_pkg::IDX_W-1:0]        o_position
);

    stbs_pkg::t_dp_cmd    dp_cmd;
    stbs_pkg::t_dp_status dp_status;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    stbs_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_search_key  (i_search_key),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_status      (dp_status),
        .o_found       (o_found),
        .o_position    (o_position)
    );

endmodule
